// ===== hdl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

   // Depth of the command queue between the byte decoder and the output sequencer
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One input item: a raw byte of the string body
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   // One result item: a decoded byte or the end marker
   typedef struct packed {
      logic [7:0] out_byte;
      logic       empty_res;
      logic       end_of_string;
   } rsp_type;

   // What the main part of a command carries
   typedef enum logic [1:0] {
      BODY_NONE = 2'd0,
      BODY_RAW  = 2'd1,
      BODY_CODE = 2'd2
   } body_kind_type;

   // Work for the output sequencer, produced for one input byte
   typedef struct packed {
      logic                flush;      // emit the waiting high surrogate first
      logic [15:0]         high_surr;  // that surrogate
      body_kind_type       kind;
      logic [20:0]         code;       // code point for BODY_CODE
      logic [2:0][7:0]     raw;        // bytes for BODY_RAW, raw[0] first
      logic [1:0]          raw_n;
      logic                last;       // append the end marker
   } cmd_type;

endpackage

// ===== hdl/json_string_unescaper_unit.sv =====
// Top level of the JSON string unescaper: decoder, command queue, output sequencer.
//
//   channel   direction  handshake            payload
//   input     in         push / full          req_data  (in_byte, last_byte)
//   result    out        pop / empty          rsp_data  (out_byte, empty_res, end_of_string)
//
// Cycles: one byte is taken per cycle while the command queue has room; the
// decoder resolves each byte in the cycle it is taken.
// Results: the sequencer sends one byte per cycle while the output register is free
// or popped; an item can expand into up to 7 results, with the end marker.
// A taken byte's command passes through the queue and then the output register.
// Reset: synchronous; clears the decoder control state, the queue and the output valid flag.
// Stalls: the four-entry queue lets input keep flowing while results wait on pop.
module json_string_unescaper_unit
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cmd_type wr_cmd;
   cmd_type rd_cmd;
   logic    front_idle;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .q_push     (q_push),
      .q_cmd      (wr_cmd),
      .q_full     (q_full),
      .front_idle (front_idle)
   );

   jsu_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (wr_cmd),
      .full   (q_full),
      .pop    (q_pop),
      .rd_cmd (rd_cmd),
      .empty  (q_empty)
   );

   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (rd_cmd),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

   // Decoder never writes a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("command written into a full queue");

   // Sequencer never retires a command from an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("command retired from an empty queue");

   // The last byte of a body leaves the decoder at its start state
   assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_data.last_byte) |=> front_idle)
      else $error("decoder not back at start after end of body");

   // The end marker carries no byte
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.end_of_string) |->
         (rsp_data.empty_res && (rsp_data.out_byte == 8'h00)))
      else $error("end marker carries data");

endmodule

// ===== hdl/jsu_front.sv =====
// Byte decoder: escape and \u state machine that turns each byte into a command.
module jsu_front
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    q_push,
   output cmd_type q_cmd,
   input  logic    q_full,
   output logic    front_idle
);

   // Character codes
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_BSPACE    = 8'h08;
   localparam logic [7:0] CH_FEED      = 8'h0C;
   localparam logic [7:0] CH_0         = 8'h30;
   localparam logic [7:0] CH_9         = 8'h39;
   localparam logic [7:0] CH_LA        = 8'h61;
   localparam logic [7:0] CH_LF_HEX    = 8'h66;
   localparam logic [7:0] CH_UA        = 8'h41;
   localparam logic [7:0] CH_UF        = 8'h46;

   // Surrogate ranges
   localparam logic [15:0] HI_MIN    = 16'hD800;
   localparam logic [15:0] HI_MAX    = 16'hDBFF;
   localparam logic [15:0] LO_MIN    = 16'hDC00;
   localparam logic [15:0] LO_MAX    = 16'hDFFF;
   localparam logic [5:0]  HI_PREFIX = 6'b110110;
   localparam logic [20:0] SUPP_BASE = 21'h10000;

   typedef enum logic [4:0] {
      PH_PLAIN   = 5'b00001,
      PH_ESC     = 5'b00010,
      PH_HEX     = 5'b00100,
      PH_PEND_BS = 5'b01000,
      PH_PEND_U  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      n;
   } raw_list_type;

   // Single-character escape; 'u' is handled by the caller
   function automatic logic [7:0] esc_map(input logic [7:0] ch);
      logic [7:0] res;
      unique case (ch)
         CH_N:    res = CH_LF;
         CH_T:    res = CH_TAB;
         CH_R:    res = CH_CR;
         CH_B:    res = CH_BSPACE;
         CH_F:    res = CH_FEED;
         default: res = ch;
      endcase
      return res;
   endfunction

   // {is_hex, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] res;
      logic [7:0] diff;
      res = '0;
      diff = '0;
      if (ch >= CH_0 && ch <= CH_9) begin
         diff = ch - CH_0;
         res = {1'b1, diff[3:0]};
      end else if (ch >= CH_LA && ch <= CH_LF_HEX) begin
         diff = ch - CH_LA + 8'd10;
         res = {1'b1, diff[3:0]};
      end else if (ch >= CH_UA && ch <= CH_UF) begin
         diff = ch - CH_UA + 8'd10;
         res = {1'b1, diff[3:0]};
      end
      return res;
   endfunction

   // Value of the leading hex digits of a four-byte group
   function automatic logic [15:0] hex_value(input logic [3:0][7:0] chars);
      logic [15:0] v;
      logic        stop;
      logic [4:0]  hd;
      v = '0;
      stop = 1'b0;
      for (int k = 0; k < 4; k++) begin
         hd = hex_digit(chars[k]);
         if (!stop && hd[4]) begin
            v = {v[11:0], hd[3:0]};
         end else begin
            stop = 1'b1;
         end
      end
      return v;
   endfunction

   // Decode the bytes of a cut-short \u group again as body text
   function automatic raw_list_type replay_tail(input logic [2:0][7:0] tail,
                                                input logic [1:0] len);
      raw_list_type res;
      logic         in_esc;
      logic         in_hex;
      logic         is_last;
      logic [7:0]   ch;
      res = '0;
      in_esc = 1'b0;
      in_hex = 1'b0;
      is_last = 1'b0;
      ch = '0;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < len) begin
            ch = tail[i];
            is_last = (2'(i) == len - 2'd1);
            if (in_hex) begin
               // only a final byte can land here; a one-byte group comes back as itself
               res.bytes[res.n] = ch;
               res.n = res.n + 2'd1;
            end else if (in_esc) begin
               in_esc = 1'b0;
               if (ch == CH_U) begin
                  if (!is_last) begin
                     in_hex = 1'b1;
                  end
               end else begin
                  res.bytes[res.n] = esc_map(ch);
                  res.n = res.n + 2'd1;
               end
            end else if (ch == CH_BACKSLASH && !is_last) begin
               in_esc = 1'b1;
            end else begin
               res.bytes[res.n] = ch;
               res.n = res.n + 2'd1;
            end
         end
      end
      return res;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [1:0]  hc_ff, hc_in;
   logic [9:0]  hs_ff, hs_in;
   logic        hp_ff, hp_in;
   logic [7:0]  hex_ff [3];
   logic        hex_we;

   logic         accept;
   logic [7:0]   ch;
   logic         last;
   logic         go_plain;
   logic         go_esc;
   logic [15:0]  cp;
   logic         cp_is_high;
   logic         cp_is_low;
   logic [2:0][7:0] tail;
   raw_list_type rep;
   cmd_type      cmd;

   assign accept     = push && !q_full;
   assign full       = q_full;
   assign ch         = req_data.in_byte;
   assign last       = req_data.last_byte;
   assign front_idle = (phase_ff == PH_PLAIN) && !hp_ff && (hc_ff == 2'd0);

   // Hex group and cut-short tail, both read at the current fill position
   always_comb begin
      cp = hex_value({ch, hex_ff[2], hex_ff[1], hex_ff[0]});
      cp_is_high = (cp >= HI_MIN) && (cp <= HI_MAX);
      cp_is_low  = (cp >= LO_MIN) && (cp <= LO_MAX);
      for (int j = 0; j < 3; j++) begin
         tail[j] = (2'(j) == hc_ff) ? ch : hex_ff[j];
      end
      rep = replay_tail(tail, hc_ff + 2'd1);
   end

   // Next state and command for the byte on the input
   always_comb begin
      phase_in = phase_ff;
      hc_in    = hc_ff;
      hs_in    = hs_ff;
      hp_in    = hp_ff;
      hex_we   = 1'b0;
      go_plain = 1'b0;
      go_esc   = 1'b0;
      cmd           = '0;
      cmd.high_surr = {HI_PREFIX, hs_ff};
      cmd.kind      = BODY_NONE;
      cmd.last      = last;

      unique case (phase_ff)
         PH_PEND_BS: begin
            if (ch == CH_BACKSLASH && !last) begin
               phase_in = PH_PEND_U;
            end else begin
               cmd.flush = hp_ff;
               hp_in     = 1'b0;
               go_plain  = 1'b1;
            end
         end
         PH_PEND_U: begin
            if (ch == CH_U && !last) begin
               phase_in = PH_HEX;
               hc_in    = 2'd0;
            end else begin
               cmd.flush = hp_ff;
               hp_in     = 1'b0;
               go_esc    = 1'b1;
            end
         end
         PH_ESC: begin
            go_esc = 1'b1;
         end
         PH_HEX: begin
            if (hc_ff == 2'd3) begin
               hc_in = 2'd0;
               if (hp_ff && cp_is_low) begin
                  // surrogate pair joins into one supplementary code point
                  cmd.kind = BODY_CODE;
                  cmd.code = SUPP_BASE + {1'b0, hs_ff, cp[9:0]};
                  hp_in    = 1'b0;
                  phase_in = PH_PLAIN;
               end else begin
                  cmd.flush = hp_ff;
                  hp_in     = 1'b0;
                  if (cp_is_high && !last) begin
                     hs_in    = cp[9:0];
                     hp_in    = 1'b1;
                     phase_in = PH_PEND_BS;
                  end else begin
                     cmd.kind = BODY_CODE;
                     cmd.code = {5'b0, cp};
                     phase_in = PH_PLAIN;
                  end
               end
            end else begin
               hex_we = 1'b1;
               hc_in  = hc_ff + 2'd1;
               if (last) begin
                  // body ended inside the group: drop \u, decode the rest as text
                  cmd.flush = hp_ff;
                  hp_in     = 1'b0;
                  cmd.kind  = BODY_RAW;
                  cmd.raw   = rep.bytes;
                  cmd.raw_n = rep.n;
                  hc_in     = 2'd0;
                  phase_in  = PH_PLAIN;
               end
            end
         end
         default: begin
            go_plain = 1'b1;
         end
      endcase

      // Byte after a backslash
      if (go_esc) begin
         phase_in = PH_PLAIN;
         if (ch == CH_U) begin
            if (!last) begin
               phase_in = PH_HEX;
               hc_in    = 2'd0;
            end
         end else begin
            cmd.kind  = BODY_RAW;
            cmd.raw   = {16'h0000, esc_map(ch)};
            cmd.raw_n = 2'd1;
         end
      end

      // Plain text; a trailing backslash is copied
      if (go_plain) begin
         if (ch == CH_BACKSLASH && !last) begin
            phase_in = PH_ESC;
         end else begin
            phase_in  = PH_PLAIN;
            cmd.kind  = BODY_RAW;
            cmd.raw   = {16'h0000, ch};
            cmd.raw_n = 2'd1;
         end
      end

      // End of body returns to the start state
      if (last) begin
         phase_in = PH_PLAIN;
         hc_in    = 2'd0;
         hp_in    = 1'b0;
         hs_in    = '0;
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.flush || (cmd.kind != BODY_NONE) || cmd.last);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         hc_ff    <= 2'd0;
         hs_ff    <= '0;
         hp_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hc_ff    <= hc_in;
         hs_ff    <= hs_in;
         hp_ff    <= hp_in;
      end
   end

   // Bytes of the current \u group
   always_ff @(posedge clock) begin
      if (accept && hex_we) begin
         hex_ff[hc_ff] <= ch;
      end
   end

endmodule

// ===== hdl/jsu_queue.sv =====
// Short command queue between the byte decoder and the output sequencer.
module jsu_queue
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wr_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type rd_cmd,
   output logic    empty
);

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;

   assign full   = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_cmd = slot_ff[rd_ptr_ff];

   // Pointer wrap and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ===== hdl/jsu_back.sv =====
// Output sequencer: expands one command into UTF-8 bytes and the end marker.
module jsu_back
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam logic [20:0] CP_LIMIT1 = 21'h80;
   localparam logic [20:0] CP_LIMIT2 = 21'h800;
   localparam logic [20:0] CP_LIMIT3 = 21'h10000;
   localparam logic [7:0]  LEAD2     = 8'hC0;
   localparam logic [7:0]  LEAD3     = 8'hE0;
   localparam logic [7:0]  LEAD4     = 8'hF0;
   localparam logic [7:0]  CONT      = 8'h80;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      n;
   } utf8_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type res;
      res = '0;
      if (cp < CP_LIMIT1) begin
         res.bytes[0] = cp[7:0];
         res.n = 3'd1;
      end else if (cp < CP_LIMIT2) begin
         res.bytes[0] = LEAD2 | {3'b0, cp[10:6]};
         res.bytes[1] = CONT | {2'b0, cp[5:0]};
         res.n = 3'd2;
      end else if (cp < CP_LIMIT3) begin
         res.bytes[0] = LEAD3 | {4'b0, cp[15:12]};
         res.bytes[1] = CONT | {2'b0, cp[11:6]};
         res.bytes[2] = CONT | {2'b0, cp[5:0]};
         res.n = 3'd3;
      end else begin
         res.bytes[0] = LEAD4 | {5'b0, cp[20:18]};
         res.bytes[1] = CONT | {2'b0, cp[17:12]};
         res.bytes[2] = CONT | {2'b0, cp[11:6]};
         res.bytes[3] = CONT | {2'b0, cp[5:0]};
         res.n = 3'd4;
      end
      return res;
   endfunction

   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   utf8_type        fl_enc;
   utf8_type        code_enc;
   logic [3:0][7:0] body_bytes;
   logic [2:0]      fl_n;
   logic [2:0]      body_n;
   logic [3:0]      total;
   logic [3:0]      idx_w;
   logic [3:0]      off;
   logic [7:0]      unit_byte;
   logic            marker;
   logic            final_unit;
   logic            step;

   // Unit list of the head command: surrogate flush, body bytes, end marker
   always_comb begin
      fl_enc   = utf8_encode({5'b0, q_cmd.high_surr});
      fl_n     = q_cmd.flush ? fl_enc.n : 3'd0;
      code_enc = utf8_encode(q_cmd.code);
      unique case (q_cmd.kind)
         BODY_CODE: begin
            body_bytes = code_enc.bytes;
            body_n     = code_enc.n;
         end
         BODY_RAW: begin
            body_bytes = {8'h00, q_cmd.raw};
            body_n     = {1'b0, q_cmd.raw_n};
         end
         default: begin
            body_bytes = '0;
            body_n     = 3'd0;
         end
      endcase
      total = {1'b0, fl_n} + {1'b0, body_n};
      idx_w = {1'b0, idx_ff};
      off   = idx_w - {1'b0, fl_n};
      if (idx_w < {1'b0, fl_n}) begin
         unit_byte = fl_enc.bytes[idx_ff[1:0]];
      end else if (idx_w < total) begin
         unit_byte = body_bytes[off[1:0]];
      end else begin
         unit_byte = 8'h00;
      end
      marker     = (idx_w == total);
      final_unit = q_cmd.last ? marker : ((idx_w + 4'd1) == total);
   end

   // One unit per cycle while a command waits and the output register is free or drains
   always_comb begin
      step         = !q_empty && (!rsp_valid_ff || rsp_pop);
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         idx_in       = final_unit ? 3'd0 : idx_ff + 3'd1;
         rsp_in       = '{out_byte: unit_byte, empty_res: marker, end_of_string: marker};
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign q_pop     = step && final_unit;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
